[rtl/core/zdc_pkg.sv]
// Package with the shared widths and types of the zigzag coordinate block.
`default_nettype none

package zdc_pkg;

  // The diagonal search covers d below 2**DIAG_BITS.
  localparam int DIAG_BITS = 31;
  localparam int POS_W     = 61;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * DIAG_BITS;
  localparam int CMP_W     = (PROD_W > POS_W) ? PROD_W : POS_W;

  typedef logic [DIAG_BITS-1:0] diag_t;
  typedef logic [DIAG_BITS:0]   hi_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [COORD_W-1:0]   coord_t;

  localparam cmp_t CMP_ONE = cmp_t'(1);

  // Triangular number of 2**DIAG_BITS: the last cell of the last reachable diagonal.
  localparam cmp_t POS_LIM = (CMP_ONE << (2 * DIAG_BITS - 1)) + (CMP_ONE << (DIAG_BITS - 1));

endpackage

`default_nettype wire

[rtl/core/zigzag_diagonal_coordinates.sv]
// Top level of the zigzag (Cantor) position to grid coordinate converter.
// A position beat is taken only while the block is idle; it then runs a binary
// search over diagonals, each probe one triangular-number multiply on the
// shared multiplier followed by one compare and bound update, DIAG_BITS-1 or
// DIAG_BITS probes, followed by one more multiply and a remainder step that
// writes the result; the next position is taken once the block is back in idle.
// Position 0 and 1 skip the search and go straight to the final multiply and
// remainder step, which give (1,1). The result sits in an output register, so a new
// position is taken while the previous result waits; the final step holds until
// that register is free.
`default_nettype none

module zigzag_diagonal_coordinates (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [60:0]     in_position,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output zdc_pkg::coord_t      out_coord_x,
  output zdc_pkg::coord_t      out_coord_y
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_FIN_MUL = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0]      state_r, state_nxt;
  zdc_pkg::cmp_t   pos_r, pos_nxt;
  zdc_pkg::diag_t  lo_r, lo_nxt;
  zdc_pkg::hi_t    hi_r, hi_nxt;
  zdc_pkg::diag_t  mid_r, mid_nxt;
  logic            out_valid_r, out_valid_nxt;
  zdc_pkg::coord_t out_x_r, out_x_nxt;
  zdc_pkg::coord_t out_y_r, out_y_nxt;

  zdc_pkg::diag_t  mul_d;
  zdc_pkg::prod_t  mul_prod_r;

  zdc_pkg::cmp_t   pos_in;
  zdc_pkg::cmp_t   pos_sat;
  zdc_pkg::cmp_t   prod_ext;
  logic            probe_high;
  zdc_pkg::diag_t  mid_if_high;
  zdc_pkg::diag_t  mid_if_low;
  logic            more_if_high;
  logic            more_if_low;
  zdc_pkg::hi_t    hi_minus_mid;
  zdc_pkg::cmp_t   rem;
  zdc_pkg::cmp_t   x_full;
  logic            out_free;

  zdc_tri_mul u_tri_mul (
    .clk        (clk),
    .mul_d      (mul_d),
    .mul_prod_r (mul_prod_r)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_coord_x = out_x_r;
  assign out_coord_y = out_y_r;
  assign out_free    = !out_valid_r || !out_stall;

  // The final steps take the triangular number of the lower bound, every probe that of the midpoint.
  assign mul_d = (state_r == S_FIN_MUL || state_r == S_FIN) ? lo_r : mid_r;

  always_comb begin
    pos_in = zdc_pkg::cmp_t'(in_position);
    if (pos_in == '0) begin
      pos_sat = zdc_pkg::CMP_ONE;
    end else if (pos_in > zdc_pkg::POS_LIM) begin
      pos_sat = zdc_pkg::POS_LIM;
    end else begin
      pos_sat = pos_in;
    end

    prod_ext   = zdc_pkg::cmp_t'(mul_prod_r);
    probe_high = (prod_ext >= pos_r);

    // Both possible next midpoints are formed ahead of the compare.
    mid_if_high  = lo_r + ((mid_r - lo_r) >> 1);
    more_if_high = ((lo_r + zdc_pkg::diag_t'(1)) < mid_r);
    hi_minus_mid = hi_r - zdc_pkg::hi_t'(mid_r);
    mid_if_low   = mid_r + hi_minus_mid[zdc_pkg::DIAG_BITS:1];
    more_if_low  = ((zdc_pkg::hi_t'(mid_r) + zdc_pkg::hi_t'(1)) < hi_r);

    rem    = pos_r - prod_ext;
    x_full = zdc_pkg::cmp_t'(lo_r) + zdc_pkg::cmp_t'(2) - rem;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt = pos_sat;
          hi_nxt  = zdc_pkg::hi_t'(1) << zdc_pkg::DIAG_BITS;
          mid_nxt = zdc_pkg::diag_t'(1) << (zdc_pkg::DIAG_BITS - 1);
          if (pos_sat == zdc_pkg::CMP_ONE) begin
            // Diagonal zero with remainder one lands on (1,1) without a search.
            lo_nxt    = '0;
            state_nxt = S_FIN_MUL;
          end else begin
            lo_nxt    = zdc_pkg::diag_t'(1);
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (probe_high) begin
          hi_nxt  = zdc_pkg::hi_t'(mid_r);
          mid_nxt = mid_if_high;
          state_nxt = more_if_high ? S_MUL : S_FIN_MUL;
        end else begin
          lo_nxt  = mid_r;
          mid_nxt = mid_if_low;
          state_nxt = more_if_low ? S_MUL : S_FIN_MUL;
        end
      end
      S_FIN_MUL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (lo_r[0]) begin
            out_x_nxt = rem[zdc_pkg::COORD_W-1:0];
            out_y_nxt = x_full[zdc_pkg::COORD_W-1:0];
          end else begin
            out_x_nxt = x_full[zdc_pkg::COORD_W-1:0];
            out_y_nxt = rem[zdc_pkg::COORD_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL || state_r == S_FIN_MUL))
    else $error("accepted position beat did not start the search");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r < mid_r) && (zdc_pkg::hi_t'(mid_r) < hi_r))
    else $error("search bounds out of order");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |->
      (rem != '0) && (rem <= zdc_pkg::cmp_t'(lo_r) + zdc_pkg::CMP_ONE))
    else $error("remainder outside its diagonal");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the final step");

endmodule

`default_nettype wire

[rtl/core/zdc_tri_mul.sv]
// Registered triangular-number unit d(d+1)/2, shared by every probe of the search.
`default_nettype none

module zdc_tri_mul (
  input  wire logic           clk,
  input  wire zdc_pkg::diag_t mul_d,
  output zdc_pkg::prod_t      mul_prod_r
);

  zdc_pkg::hi_t   d_inc;
  zdc_pkg::diag_t op_a;
  zdc_pkg::diag_t op_b;
  zdc_pkg::prod_t mul_prod_nxt;

  // Halve whichever factor is even so that both operands stay DIAG_BITS wide.
  always_comb begin
    d_inc = zdc_pkg::hi_t'(mul_d) + zdc_pkg::hi_t'(1);
    if (mul_d[0]) begin
      op_a = mul_d;
      op_b = d_inc[zdc_pkg::DIAG_BITS:1];
    end else begin
      op_a = mul_d >> 1;
      op_b = d_inc[zdc_pkg::DIAG_BITS-1:0];
    end
    mul_prod_nxt = zdc_pkg::prod_t'(op_a) * zdc_pkg::prod_t'(op_b);
  end

  always_ff @(posedge clk) begin
    mul_prod_r <= mul_prod_nxt;
  end

endmodule

`default_nettype wire

[tb/zigzag_diagonal_coordinates_test.sv]
// Self-checking testbench that drives zigzag positions into the converter and checks each cell.
`timescale 1ns / 1ps

module zigzag_diagonal_coordinates_test;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          TAIL_CYCLES = 80;
  localparam int          RANDOM_ITEMS = 800;
  localparam logic [60:0] POS_MAX = {61{1'b1}};

  typedef struct packed {
    logic [60:0]     position;
    zdc_pkg::coord_t x;
    zdc_pkg::coord_t y;
  } cell_t;

  // Holds the cells still owed by the block, oldest first, and grades each result beat.
  class coord_scoreboard;
    cell_t pending_cells[$];
    int    errors = 0;

    // Triangular number d(d+1)/2, halving whichever factor is even first.
    function logic [63:0] tri_num(logic [63:0] d);
      logic [63:0] a;
      logic [63:0] b;
      a = d;
      b = d + 64'd1;
      if (a[0]) b = b >> 1;
      else a = a >> 1;
      return a * b;
    endfunction

    function cell_t locate_cell(logic [60:0] pos);
      logic [63:0] n;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] last_cell;
      cell_t       c;
      c.position = pos;
      hi = 64'd1 << zdc_pkg::DIAG_BITS;
      last_cell = tri_num(hi);
      n = {3'b000, pos};
      if (n == 64'd0) n = 64'd1;
      if (n > last_cell) n = last_cell;
      if (n == 64'd1) begin
        c.x = 32'd1;
        c.y = 32'd1;
        return c;
      end
      // Largest diagonal whose triangular number lies below the position.
      lo = 64'd1;
      while (lo + 64'd1 < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (tri_num(mid) >= n) hi = mid;
        else lo = mid;
      end
      r = n - tri_num(lo);
      x = lo + 64'd2 - r;
      y = r;
      if (lo[0]) begin
        c.x = y[31:0];
        c.y = x[31:0];
      end else begin
        c.x = x[31:0];
        c.y = y[31:0];
      end
      return c;
    endfunction

    function void note_position(logic [60:0] pos);
      pending_cells.push_back(locate_cell(pos));
    endfunction

    function void check_cell(zdc_pkg::coord_t got_x, zdc_pkg::coord_t got_y);
      cell_t want;
      if (pending_cells.size() == 0) begin
        $display("%0t: result beat (%0d, %0d) with no position outstanding", $time,
                 got_x, got_y);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      if (got_x !== want.x) begin
        $display("%0t: position %0d coord_x expected %0d, actual %0d", $time,
                 want.position, want.x, got_x);
        errors++;
      end
      if (got_y !== want.y) begin
        $display("%0t: position %0d coord_y expected %0d, actual %0d", $time,
                 want.position, want.y, got_y);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_cells.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [60:0]     in_position;
  logic            out_valid;
  logic            out_stall;
  zdc_pkg::coord_t out_coord_x;
  zdc_pkg::coord_t out_coord_y;

  coord_scoreboard sb = new();
  int              idle_odds = 0;
  int              cycle_count = 0;

  zigzag_diagonal_coordinates u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_coord_x (out_coord_x),
    .out_coord_y (out_coord_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Both channels are sampled with the values they held just before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_position(in_position);
    if (rst_n && out_valid && !out_stall) sb.check_cell(out_coord_x, out_coord_y);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts; none while idle_odds is zero.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called just after an edge; returns on the edge at which the beat is taken.
  task automatic send_position(input logic [60:0] pos);
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [60:0] near_diagonal(logic [63:0] d);
    logic [63:0] p;
    p = sb.tri_num(d) + 64'($urandom_range(0, 3)) - 64'd1;
    if (p > {3'b000, POS_MAX}) p = {3'b000, POS_MAX};
    return p[60:0];
  endfunction

  initial begin
    logic [60:0] directed[$];
    logic [60:0] pos;
    int          kind;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_position <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and one, the first diagonals, exact triangular boundaries and the field extremes.
    directed = '{61'd0, 61'd1, 61'd2, 61'd3, 61'd4, 61'd5, 61'd6, 61'd7,
                 61'd10, 61'd11, POS_MAX, POS_MAX - 61'd1, 61'd1 << 60,
                 61'(sb.tri_num(64'h7FFF_FFFF)), 61'(sb.tri_num(64'h7FFF_FFFF)) + 61'd1,
                 61'(sb.tri_num(64'h7FFF_FFFF)) - 61'd1,
                 61'(sb.tri_num(64'h4000_0000)), 61'(sb.tri_num(64'h4000_0000)) + 61'd1,
                 61'(sb.tri_num(64'd65535)), 61'(sb.tri_num(64'd65535)) + 61'd1,
                 61'h0AAA_AAAA_AAAA_AAAA, 61'h1555_5555_5555_5555, 61'd1 << 32};
    idle_odds = 4;
    foreach (directed[i]) send_position(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) idle_odds = 0;
      if (i == 300) idle_odds = 2;
      if (i == 500) begin
        drain_results();
        idle_odds = 6;
      end
      if (i == RANDOM_ITEMS - 100) idle_odds = 0;
      kind = $urandom_range(0, 9);
      if (kind < 2) pos = 61'($urandom_range(0, 5000));
      else if (kind < 4) pos = near_diagonal(64'($urandom_range(1, 100000)));
      else if (kind < 6) pos = near_diagonal(64'($urandom_range(1, 32'h7FFF_FFFF)));
      else pos = 61'({$urandom(), $urandom()});
      send_position(pos);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
